FILE: rtl/core/ccfr_pkg.sv
// Package for the COBS frame receiver core: sizes, limits, result codes.
// No dependencies; imported by ccfr_crc16 and cobs_crc_frame_receiver_core.
package ccfr_pkg;

  localparam int MAX_PACKET  = 256;
  localparam int CODED_LIMIT = 300;

  localparam logic [8:0]  CODED_LAST    = 9'(CODED_LIMIT - 1);
  localparam logic [15:0] LEN_MIN       = 16'd6;
  localparam logic [15:0] LEN_MAX       = 16'(MAX_PACKET);
  localparam logic [15:0] LEN_OVERHEAD  = 16'd5;
  localparam logic [8:0]  DEC_SAT       = 9'd511;
  localparam logic [8:0]  DEC_MIN       = 9'd4;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [7:0]  CODE_FULL     = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LEN_RANGE = 3'd2,
    ST_LEN_MISM  = 3'd3,
    ST_CRC_BAD   = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_MALFORMED = 3'd6
  } status_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

endpackage

FILE: rtl/core/ccfr_crc16.sv
// One-word update of a CRC-16/CCITT (MSB first), bitwise parallel.
// Depends on ccfr_pkg for the polynomial.
module ccfr_crc16 import ccfr_pkg::*; (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

FILE: rtl/core/cobs_crc_frame_receiver_core.sv
// COBS deframer with CRC-16/CCITT frame check: decodes words and reports a frame verdict.
// Depends on ccfr_pkg and ccfr_crc16.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | in_byte
//   out     | out_valid / out_ready| kind, data_byte, byte_index, status, command, payload_len
//
// Each accepted word is decoded in the cycle it is taken and its result, if any,
// appears in the output register on the next cycle; one word per cycle sustained while out_ready is high.
// A result waiting in the output register blocks input only while out_ready is low.
// Synchronous reset clears the frame state and the output valid flag.
module cobs_crc_frame_receiver_core import ccfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [8:0] byte_index,
  output logic [2:0] status,
  output logic [7:0] command,
  output logic [7:0] payload_len
);

  logic [8:0]  coded_count,    coded_count_next;
  logic [7:0]  group_left,     group_left_next;
  logic        group_was_full, group_was_full_next;
  logic [8:0]  decoded_count,  decoded_count_next;
  logic [15:0] length_field,   length_field_next;
  logic [7:0]  command_byte,   command_byte_next;
  logic [15:0] running_crc,    running_crc_next;
  logic [7:0]  tail0,          tail0_next;
  logic [7:0]  tail1,          tail1_next;

  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_data;
  logic [8:0]  res_index;
  status_t     res_status;
  logic [7:0]  res_command;
  logic [7:0]  res_plen;

  logic [15:0] crc_stepped;
  logic        accept;
  logic        do_push;
  logic [7:0]  push_val;
  logic        do_clear;
  logic [15:0] len_minus;

  ccfr_crc16 u_crc (
    .crc_in  (running_crc),
    .data    (tail0),
    .crc_out (crc_stepped)
  );

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign len_minus = length_field - LEN_OVERHEAD;

  always_comb begin
    coded_count_next    = coded_count;
    group_left_next     = group_left;
    group_was_full_next = group_was_full;
    decoded_count_next  = decoded_count;
    length_field_next   = length_field;
    command_byte_next   = command_byte;
    running_crc_next    = running_crc;
    tail0_next          = tail0;
    tail1_next          = tail1;
    res_valid   = 1'b0;
    res_kind    = KIND_DATA;
    res_data    = 8'd0;
    res_index   = 9'd0;
    res_status  = ST_OK;
    res_command = 8'd0;
    res_plen    = 8'd0;
    do_push     = 1'b0;
    push_val    = 8'd0;
    do_clear    = 1'b0;

    if (in_byte == 8'd0) begin
      if (coded_count != 9'd0) begin
        res_valid = 1'b1;
        res_kind  = KIND_VERDICT;
        do_clear  = 1'b1;
        if (group_left != 8'd0) begin
          res_status = ST_MALFORMED;
        end else if (decoded_count < DEC_MIN) begin
          res_status = ST_SHORT;
        end else if (length_field < LEN_MIN || length_field > LEN_MAX) begin
          res_status = ST_LEN_RANGE;
        end else if ({7'd0, decoded_count} != length_field) begin
          res_status = ST_LEN_MISM;
        end else if (running_crc != {tail1, tail0}) begin
          res_status = ST_CRC_BAD;
        end else begin
          res_status  = ST_OK;
          res_command = command_byte;
          res_plen    = len_minus[7:0];
        end
      end
    end else if (coded_count >= CODED_LAST) begin
      res_valid  = 1'b1;
      res_kind   = KIND_VERDICT;
      res_status = ST_OVERFLOW;
      do_clear   = 1'b1;
    end else begin
      coded_count_next = coded_count + 9'd1;
      if (group_left == 8'd0) begin
        group_left_next     = in_byte - 8'd1;
        group_was_full_next = (in_byte == CODE_FULL);
        do_push             = !group_was_full;
        push_val            = 8'd0;
      end else begin
        group_left_next = group_left - 8'd1;
        do_push         = 1'b1;
        push_val        = in_byte;
      end
    end

    if (do_push) begin
      if (decoded_count == 9'd0) begin
        length_field_next = {length_field[15:8], push_val};
      end else if (decoded_count == 9'd1) begin
        length_field_next = {push_val, length_field[7:0]};
      end else if (decoded_count == 9'd2) begin
        command_byte_next = push_val;
      end
      if (decoded_count >= 9'd2) begin
        running_crc_next = crc_stepped;
      end
      tail0_next = tail1;
      tail1_next = push_val;
      if (decoded_count < DEC_SAT) begin
        decoded_count_next = decoded_count + 9'd1;
      end
      res_valid = 1'b1;
      res_kind  = KIND_DATA;
      res_data  = push_val;
      res_index = decoded_count;
    end

    if (do_clear) begin
      coded_count_next    = 9'd0;
      group_left_next     = 8'd0;
      group_was_full_next = 1'b1;
      decoded_count_next  = 9'd0;
      length_field_next   = 16'd0;
      command_byte_next   = 8'd0;
      running_crc_next    = CRC_INIT;
      tail0_next          = 8'd0;
      tail1_next          = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coded_count    <= 9'd0;
      group_left     <= 8'd0;
      group_was_full <= 1'b1;
      decoded_count  <= 9'd0;
      length_field   <= 16'd0;
      command_byte   <= 8'd0;
      running_crc    <= CRC_INIT;
      tail0          <= 8'd0;
      tail1          <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        coded_count    <= coded_count_next;
        group_left     <= group_left_next;
        group_was_full <= group_was_full_next;
        decoded_count  <= decoded_count_next;
        length_field   <= length_field_next;
        command_byte   <= command_byte_next;
        running_crc    <= running_crc_next;
        tail0          <= tail0_next;
        tail1          <= tail1_next;
        out_valid      <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind        <= res_kind;
      data_byte   <= res_data;
      byte_index  <= res_index;
      status      <= res_status;
      command     <= res_command;
      payload_len <= res_plen;
    end
  end

endmodule
